FILE: rtl/shmh_pkg.sv
// Shared types and constants for the SHA-256 message hasher.
// Holds the round constants, the initial hash value and the control structs.
// Depends on nothing.
package shmh_pkg;

  typedef logic [7:0][31:0] hash_t;

  typedef struct packed {
    logic       byte_en;
    logic [7:0] byte_val;
    logic       word_en;
  } sched_ctl_t;

  typedef struct packed {
    logic        load;
    logic        step;
    logic [31:0] k;
  } round_ctl_t;

  localparam hash_t IV_HASH = {
    32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
    32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
  };

  localparam logic [7:0] PAD_BYTE = 8'h80;

  localparam logic [31:0] K_TAB [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

endpackage

FILE: rtl/sha256_message_hasher_top.sv
// SHA-256 message hasher top level: sequencer, hash words, length and output.
// Instantiates shmh_sched and shmh_round; depends on shmh_pkg.
//
// Usage: the input channel takes one beat per item, carrying an optional
// message byte and a flag that closes the message. The output channel gives
// eight beats per digest, word 0 (most significant) first, with digest_done
// set on the last one.
// An input beat that completes no 64-byte block and does not close the message
// is taken without stalling the input. A beat that completes a block also loads
// the round unit in its own cycle, then holds the input stalled while the 64
// rounds run through the single round unit and the result is added into the
// hash words.
// A closing beat starts padding, which writes one pad byte per cycle through the
// block buffer (0x80, zeros, then the eight length bytes), pausing while a full
// block is compressed, and compresses once or twice before the first digest
// word appears. The digest words then leave at one per cycle unless the
// receiver stalls; a stalled word holds and the input stays stalled until the
// eighth word is taken, after which the hash returns to its initial value. Reset
// clears the sequencer and the length and loads the initial hash value at once.
module sha256_message_hasher_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        byte_present_i,
  input  logic        message_end_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] digest_word_o,
  output logic [2:0]  word_number_o,
  output logic        digest_done_o
);
  import shmh_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_RND,
    ST_FOLD,
    ST_OUT
  } state_e;

  state_e      state_q, state_d;
  logic [5:0]  cnt_q, cnt_d;
  logic [63:0] bits_q, bits_d;
  logic [5:0]  rnd_q, rnd_d;
  logic [2:0]  idx_q, idx_d;
  logic        sent_q, sent_d;
  logic        two_q, two_d;
  logic        fin_q, fin_d;
  logic        pad_q, pad_d;
  hash_t       hash_q, hash_d;
  hash_t       v;
  logic [31:0] w;
  sched_ctl_t  sctl;
  round_ctl_t  rctl;

  shmh_sched u_sched (
    .clk_i (clk_i),
    .ctl_i (sctl),
    .w_o   (w)
  );

  shmh_round u_round (
    .clk_i  (clk_i),
    .ctl_i  (rctl),
    .hash_i (hash_q),
    .w_i    (w),
    .v_o    (v)
  );

  assign in_stall_o    = (state_q != ST_IDLE);
  assign out_valid_o   = (state_q == ST_OUT);
  assign digest_word_o = hash_q[0];
  assign word_number_o = idx_q;
  assign digest_done_o = (idx_q == 3'd7);

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    bits_d  = bits_q;
    rnd_d   = rnd_q;
    idx_d   = idx_q;
    sent_d  = sent_q;
    two_d   = two_q;
    fin_d   = fin_q;
    pad_d   = pad_q;
    hash_d  = hash_q;
    sctl    = '0;
    rctl    = '0;
    rctl.k  = K_TAB[rnd_q];
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          if (byte_present_i) begin
            sctl.byte_en  = 1'b1;
            sctl.byte_val = data_byte_i;
            cnt_d         = cnt_q + 6'd1;
            bits_d        = bits_q + 64'd8;
          end
          if (message_end_i) begin
            pad_d   = 1'b1;
            state_d = ST_PAD;
          end
          if (byte_present_i && (cnt_q == 6'd63)) begin
            rctl.load = 1'b1;
            rnd_d     = '0;
            state_d   = ST_RND;
          end
        end
      end
      ST_PAD: begin
        sctl.byte_en = 1'b1;
        if (!sent_q) begin
          sctl.byte_val = PAD_BYTE;
          sent_d        = 1'b1;
          if (cnt_q[5:3] == 3'b111) begin
            two_d = 1'b1;
          end
        end else if (!two_q && (cnt_q[5:3] == 3'b111)) begin
          sctl.byte_val = bits_q[{~cnt_q[2:0], 3'b000} +: 8];
          fin_d         = 1'b1;
        end else begin
          sctl.byte_val = '0;
        end
        cnt_d = cnt_q + 6'd1;
        if (cnt_q == 6'd63) begin
          rctl.load = 1'b1;
          rnd_d     = '0;
          state_d   = ST_RND;
        end
      end
      ST_RND: begin
        rctl.step    = 1'b1;
        sctl.word_en = 1'b1;
        rnd_d        = rnd_q + 6'd1;
        if (rnd_q == 6'd63) begin
          state_d = ST_FOLD;
        end
      end
      ST_FOLD: begin
        for (int i = 0; i < 8; i++) begin
          hash_d[i] = hash_q[i] + v[i];
        end
        two_d = 1'b0;
        if (fin_q) begin
          idx_d   = '0;
          state_d = ST_OUT;
        end else if (pad_q) begin
          state_d = ST_PAD;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_OUT: begin
        if (!out_stall_i) begin
          hash_d = {IV_HASH[idx_q], hash_q[7:1]};
          idx_d  = idx_q + 3'd1;
          if (idx_q == 3'd7) begin
            state_d = ST_IDLE;
            cnt_d   = '0;
            bits_d  = '0;
            sent_d  = 1'b0;
            two_d   = 1'b0;
            fin_d   = 1'b0;
            pad_d   = 1'b0;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      bits_q  <= '0;
      rnd_q   <= '0;
      idx_q   <= '0;
      sent_q  <= 1'b0;
      two_q   <= 1'b0;
      fin_q   <= 1'b0;
      pad_q   <= 1'b0;
      hash_q  <= IV_HASH;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      bits_q  <= bits_d;
      rnd_q   <= rnd_d;
      idx_q   <= idx_d;
      sent_q  <= sent_d;
      two_q   <= two_d;
      fin_q   <= fin_d;
      pad_q   <= pad_d;
      hash_q  <= hash_d;
    end
  end

endmodule

FILE: rtl/shmh_sched.sv
// Block buffer and message schedule window: sixteen 32-bit words.
// Bytes shift in one at a time; during rounds the window yields one word per cycle.
// Depends on shmh_pkg.
module shmh_sched (
  input  logic                 clk_i,
  input  shmh_pkg::sched_ctl_t ctl_i,
  output logic [31:0]          w_o
);
  import shmh_pkg::*;

  logic [31:0] win_q [16];
  logic [31:0] win_d [16];
  logic [31:0] x, y, s0, s1, w_new;

  assign x = win_q[1];
  assign y = win_q[14];
  assign s0 = {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ (x >> 3);
  assign s1 = {y[16:0], y[31:17]} ^ {y[18:0], y[31:19]} ^ (y >> 10);
  assign w_new = s1 + win_q[9] + s0 + win_q[0];
  assign w_o = win_q[0];

  always_comb begin
    for (int i = 0; i < 16; i++) begin
      win_d[i] = win_q[i];
    end
    if (ctl_i.byte_en) begin
      for (int i = 0; i < 15; i++) begin
        win_d[i] = {win_q[i][23:0], win_q[i+1][31:24]};
      end
      win_d[15] = {win_q[15][23:0], ctl_i.byte_val};
    end else if (ctl_i.word_en) begin
      for (int i = 0; i < 15; i++) begin
        win_d[i] = win_q[i+1];
      end
      win_d[15] = w_new;
    end
  end

  always_ff @(posedge clk_i) begin
    win_q <= win_d;
  end

endmodule

FILE: rtl/shmh_round.sv
// SHA-256 round unit: the eight working variables and one round per cycle.
// Loaded from the hash words, then stepped with one constant and one schedule word.
// Depends on shmh_pkg.
module shmh_round (
  input  logic                 clk_i,
  input  shmh_pkg::round_ctl_t ctl_i,
  input  shmh_pkg::hash_t      hash_i,
  input  logic [31:0]          w_i,
  output shmh_pkg::hash_t      v_o
);
  import shmh_pkg::*;

  hash_t       v_q, v_d;
  logic [31:0] a, e, big0, big1, choose, major, t1, t2;

  assign a = v_q[0];
  assign e = v_q[4];
  assign big1 = {e[5:0], e[31:6]} ^ {e[10:0], e[31:11]} ^ {e[24:0], e[31:25]};
  assign choose = (e & v_q[5]) ^ (~e & v_q[6]);
  assign t1 = v_q[7] + big1 + choose + ctl_i.k + w_i;
  assign big0 = {a[1:0], a[31:2]} ^ {a[12:0], a[31:13]} ^ {a[21:0], a[31:22]};
  assign major = (a & v_q[1]) ^ (a & v_q[2]) ^ (v_q[1] & v_q[2]);
  assign t2 = big0 + major;
  assign v_o = v_q;

  always_comb begin
    v_d = v_q;
    if (ctl_i.load) begin
      v_d = hash_i;
    end else if (ctl_i.step) begin
      v_d[7] = v_q[6];
      v_d[6] = v_q[5];
      v_d[5] = v_q[4];
      v_d[4] = v_q[3] + t1;
      v_d[3] = v_q[2];
      v_d[2] = v_q[1];
      v_d[1] = v_q[0];
      v_d[0] = t1 + t2;
    end
  end

  always_ff @(posedge clk_i) begin
    v_q <= v_d;
  end

endmodule
